>>> design/mhsd_pkg.sv
// ----------------------------------------------------------------------------
// mhsd_pkg
// Shared types and constants for the MJPEG HTTP stream deframer.
// ----------------------------------------------------------------------------
package mhsd_pkg;

    localparam int LEN_W              = 20;
    localparam int HEADER_WINDOW_DEF  = 512;
    localparam int QUEUE_DEPTH        = 3;

    localparam logic [LEN_W-1:0] MAX_FRAME_RESET = LEN_W'(256 * 1024);

    localparam logic [7:0]  MARK_BYTE = 8'hFF;
    localparam logic [7:0]  SOI_BYTE  = 8'hD8;
    localparam logic [7:0]  EOI_BYTE  = 8'hD9;
    localparam logic [7:0]  CR_BYTE   = 8'h0D;
    localparam logic [7:0]  LF_BYTE   = 8'h0A;
    localparam logic [31:0] HDR_END   = {CR_BYTE, LF_BYTE, CR_BYTE, LF_BYTE};

    // input kind codes
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef struct packed {
        logic [7:0]       byte_out;
        logic             frame_start;
        logic             frame_end;
        logic             frame_abort;
        logic [LEN_W-1:0] frame_length;
        logic             last;
    } result_t;

endpackage

>>> design/mjpeg_http_stream_deframer.sv
// ----------------------------------------------------------------------------
// mjpeg_http_stream_deframer
// Skips the HTTP header of an MJPEG response and forwards JPEG frames.
// ----------------------------------------------------------------------------
// Input channel (s_): one item per handshake; tuser is the kind (0 = stream
// byte, 1 = restart after reconnect), tdata the byte. A restart clears the
// parser and gives no result; max_frame_bytes keeps its value.
// Result channel (m_): frame bytes with start, end and abort flags in tuser,
// byte and running frame length in tdata, tlast on the last result of an item.
// cfg_wr_en/cfg_wr_data write max_frame_bytes; write only while idle.
// Each item is parsed in the cycle it is accepted and its results are
// registered into a three-entry result queue whose head drives the m_ ports.
// Throughput: one item per cycle while s_tready is high. An item that opens
// a frame (FF D8) pushes two results and can hold off the next item;
// s_tready is high while at most one result is queued.
// When the receiver stalls, the queue fills and s_tready drops; nothing is
// lost. Reset empties the queue, clears the parser and sets max_frame_bytes
// to 262144.
// ----------------------------------------------------------------------------
module mjpeg_http_stream_deframer #(
    parameter int HEADER_WINDOW = mhsd_pkg::HEADER_WINDOW_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic [mhsd_pkg::LEN_W-1:0] cfg_wr_data,   // max_frame_bytes
    // input stream
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,         // [7:0] data_byte
    input  logic                     s_tuser,         // [0] kind
    // result stream
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [31:0]              m_tdata,         // [7:0] byte_out,
                                                      // [27:8] frame_length,
                                                      // [31:28] zero
    output logic [2:0]               m_tuser,         // [0] frame_start,
                                                      // [1] frame_end,
                                                      // [2] frame_abort
    output logic                     m_tlast
);
    import mhsd_pkg::*;

    localparam int CNT_W = $clog2(HEADER_WINDOW);
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

    // parser state
    logic [LEN_W-1:0] max_bytes_reg;
    logic             header_done_reg, header_done_next;
    logic [CNT_W-1:0] header_count_reg, header_count_next;
    logic [23:0]      recent_reg, recent_next;
    logic             in_frame_reg, in_frame_next;
    logic             prev_ff_reg, prev_ff_next;
    logic [LEN_W-1:0] frame_count_reg, frame_count_next;

    // result queue, slot 0 is the head
    result_t          q_reg [QUEUE_DEPTH];
    result_t          q_next [QUEUE_DEPTH];
    logic [QC_W-1:0]  qcnt_reg, qcnt_next;

    logic             accept;
    logic             pop;
    logic [1:0]       n_push;
    result_t          res0, res1;
    logic [31:0]      hdr_word;
    logic [CNT_W-1:0] hc_inc;
    logic [LEN_W-1:0] fc_inc;
    logic             is_end;

    assign s_tready = (qcnt_reg <= QC_W'(1));
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (qcnt_reg != '0);
    assign pop      = m_tvalid && m_tready;

    assign m_tdata  = {4'b0000, q_reg[0].frame_length, q_reg[0].byte_out};
    assign m_tuser  = {q_reg[0].frame_abort, q_reg[0].frame_end, q_reg[0].frame_start};
    assign m_tlast  = q_reg[0].last;

    assign hdr_word = {recent_reg, s_tdata};
    assign hc_inc   = header_count_reg + CNT_W'(1);
    assign fc_inc   = frame_count_reg + LEN_W'(1);
    assign is_end   = prev_ff_reg && (s_tdata == EOI_BYTE);

    // parse one item
    always_comb begin
        header_done_next  = header_done_reg;
        header_count_next = header_count_reg;
        recent_next       = recent_reg;
        in_frame_next     = in_frame_reg;
        prev_ff_next      = prev_ff_reg;
        frame_count_next  = frame_count_reg;
        res0              = '0;
        res1              = '0;
        n_push            = 2'd0;
        if (accept) begin
            if (s_tuser == KIND_RESTART) begin
                header_done_next  = 1'b0;
                header_count_next = '0;
                recent_next       = '0;
                in_frame_next     = 1'b0;
                prev_ff_next      = 1'b0;
                frame_count_next  = '0;
            end else if (!header_done_reg) begin
                if (header_count_reg < CNT_W'(HEADER_WINDOW - 1)) begin
                    recent_next       = hdr_word[23:0];
                    header_count_next = hc_inc;
                    if (hc_inc >= CNT_W'(4) && hdr_word == HDR_END) begin
                        header_count_next = '0;
                        header_done_next  = 1'b1;
                    end
                end else begin
                    // window full: drop the byte and wrap
                    header_count_next = '0;
                end
            end else if (!in_frame_reg) begin
                if (prev_ff_reg && s_tdata == SOI_BYTE) begin
                    res0.byte_out     = MARK_BYTE;
                    res0.frame_start  = 1'b1;
                    res0.frame_length = LEN_W'(1);
                    res1.byte_out     = SOI_BYTE;
                    res1.frame_length = LEN_W'(2);
                    res1.last         = 1'b1;
                    n_push            = 2'd2;
                    frame_count_next  = LEN_W'(2);
                    in_frame_next     = 1'b1;
                    prev_ff_next      = 1'b0;
                end else begin
                    prev_ff_next = (s_tdata == MARK_BYTE);
                end
            end else if (frame_count_reg >= max_bytes_reg) begin
                // over length: drop the byte and report the abort
                res0.frame_abort  = 1'b1;
                res0.frame_length = frame_count_reg;
                res0.last         = 1'b1;
                n_push            = 2'd1;
                in_frame_next     = 1'b0;
                prev_ff_next      = 1'b0;
                frame_count_next  = '0;
            end else begin
                res0.byte_out     = s_tdata;
                res0.frame_end    = is_end;
                res0.frame_length = fc_inc;
                res0.last         = 1'b1;
                n_push            = 2'd1;
                frame_count_next  = fc_inc;
                if (is_end) begin
                    in_frame_next = 1'b0;
                    prev_ff_next  = 1'b0;
                end else begin
                    prev_ff_next  = (s_tdata == MARK_BYTE);
                end
            end
        end
    end

    // queue update: shift out the head, then append new results
    always_comb begin
        logic [QC_W-1:0] remain;
        remain = qcnt_reg - (pop ? QC_W'(1) : QC_W'(0));
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop) begin
                q_next[i] = (i < QUEUE_DEPTH - 1) ? q_reg[(i + 1) % QUEUE_DEPTH] : q_reg[i];
            end else begin
                q_next[i] = q_reg[i];
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (n_push != 2'd0 && QC_W'(i) == remain) begin
                q_next[i] = res0;
            end
            if (n_push == 2'd2 && QC_W'(i) == remain + QC_W'(1)) begin
                q_next[i] = res1;
            end
        end
        qcnt_next = remain + QC_W'(n_push);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg    <= MAX_FRAME_RESET;
            header_done_reg  <= 1'b0;
            header_count_reg <= '0;
            recent_reg       <= '0;
            in_frame_reg     <= 1'b0;
            prev_ff_reg      <= 1'b0;
            frame_count_reg  <= '0;
            qcnt_reg         <= '0;
        end else begin
            if (cfg_wr_en) begin
                max_bytes_reg <= cfg_wr_data;
            end
            header_done_reg  <= header_done_next;
            header_count_reg <= header_count_next;
            recent_reg       <= recent_next;
            in_frame_reg     <= in_frame_next;
            prev_ff_reg      <= prev_ff_next;
            frame_count_reg  <= frame_count_next;
            qcnt_reg         <= qcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule
